// File: rtl/htes_pkg.sv
// Shared types and character constants for the tag and entity stripper.
package htes_pkg;

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_LF    = 8'h0a;
	localparam logic [7:0] CHAR_CR    = 8'h0d;
	localparam logic [7:0] CHAR_SP    = 8'h20;
	localparam logic [7:0] CHAR_HASH  = 8'h23;
	localparam logic [7:0] CHAR_DOLR  = 8'h24;
	localparam logic [7:0] CHAR_PCT   = 8'h25;
	localparam logic [7:0] CHAR_AMP   = 8'h26;
	localparam logic [7:0] CHAR_STAR  = 8'h2a;
	localparam logic [7:0] CHAR_SEMI  = 8'h3b;
	localparam logic [7:0] CHAR_LT    = 8'h3c;
	localparam logic [7:0] CHAR_GT    = 8'h3e;
	localparam logic [7:0] CHAR_BSL   = 8'h5c;
	localparam logic [7:0] CHAR_CARET = 8'h5e;
	localparam logic [7:0] CHAR_USCR  = 8'h5f;
	localparam logic [7:0] CHAR_B     = 8'h62;
	localparam logic [7:0] CHAR_G     = 8'h67;
	localparam logic [7:0] CHAR_L     = 8'h6c;
	localparam logic [7:0] CHAR_N     = 8'h6e;
	localparam logic [7:0] CHAR_P     = 8'h70;
	localparam logic [7:0] CHAR_S     = 8'h73;
	localparam logic [7:0] CHAR_T     = 8'h74;
	localparam logic [7:0] CHAR_U     = 8'h75;
	localparam logic [7:0] CHAR_LBRC  = 8'h7b;
	localparam logic [7:0] CHAR_RBRC  = 8'h7d;
	localparam logic [7:0] CHAR_TILDE = 8'h7e;

	localparam logic [2:0] SKIP_SHORT = 3'd3;
	localparam logic [2:0] SKIP_LONG  = 3'd5;
	localparam logic [1:0] RUN_LEFT   = 2'd3;

	typedef struct packed {
		logic       emit;
		logic       run;
		logic [7:0] data;
		logic       in_tag;
		logic [2:0] skip;
	} dec_t;

endpackage

// File: rtl/htes_if.sv
// Request channel interfaces for text input and plain text output.
interface htes_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic [7:0] ahead_one;
	logic [7:0] ahead_two;
	logic [7:0] ahead_three;
	logic [7:0] ahead_four;
	logic [7:0] ahead_five;

	modport source (output valid, text_byte, ahead_one, ahead_two, ahead_three,
		ahead_four, ahead_five, input ready);
	modport sink (input valid, text_byte, ahead_one, ahead_two, ahead_three,
		ahead_four, ahead_five, output ready);
endinterface

interface htes_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;

	modport source (output valid, out_byte, last_of_run, input ready);
	modport sink (input valid, out_byte, last_of_run, output ready);
endinterface

// File: rtl/htes_decode.sv
// Byte classifier: next state and results for one registered text byte.
module htes_decode (
	input  logic             in_tag,
	input  logic [2:0]       skip,
	input  logic [7:0]       text_byte,
	input  logic [7:0]       ahead_one,
	input  logic [7:0]       ahead_two,
	input  logic [7:0]       ahead_three,
	input  logic [7:0]       ahead_four,
	input  logic [7:0]       ahead_five,
	output htes_pkg::dec_t   dec
);
	import htes_pkg::*;

	logic m_lt, m_gt, m_nbsp, m_bull;

	assign m_lt   = ahead_one == CHAR_L && ahead_two == CHAR_T && ahead_three == CHAR_SEMI;
	assign m_gt   = ahead_one == CHAR_G && ahead_two == CHAR_T && ahead_three == CHAR_SEMI;
	assign m_nbsp = ahead_one == CHAR_N && ahead_two == CHAR_B && ahead_three == CHAR_S &&
		ahead_four == CHAR_P && ahead_five == CHAR_SEMI;
	assign m_bull = ahead_one == CHAR_B && ahead_two == CHAR_U && ahead_three == CHAR_L &&
		ahead_four == CHAR_L && ahead_five == CHAR_SEMI;

	always_comb begin
		dec        = '0;
		dec.in_tag = in_tag;
		dec.skip   = skip;
		dec.data   = text_byte;
		if (text_byte == CHAR_NUL) begin
			dec.in_tag = 1'b0;
			dec.skip   = 3'd0;
		end else if (skip != 3'd0) begin
			dec.skip = skip - 3'd1;
		end else begin
			unique case (text_byte) inside
				CHAR_LT: begin
					dec.in_tag = 1'b1;
					if (ahead_one == CHAR_P) begin
						dec.emit = 1'b1;
						dec.run  = 1'b1;
						dec.data = CHAR_CR;
					end
				end
				CHAR_GT: begin
					dec.in_tag = 1'b0;
				end
				CHAR_AMP: begin
					if (m_lt) begin
						dec.in_tag = 1'b1;
						dec.skip   = SKIP_SHORT;
					end else if (m_gt) begin
						dec.in_tag = 1'b0;
						dec.skip   = SKIP_SHORT;
					end else if (m_nbsp) begin
						dec.skip = SKIP_LONG;
					end else if (m_bull) begin
						dec.skip = SKIP_LONG;
						dec.emit = 1'b1;
						dec.data = CHAR_STAR;
					end
				end
				CHAR_TAB, CHAR_BSL, CHAR_DOLR, CHAR_LBRC, CHAR_RBRC, CHAR_TILDE,
				CHAR_CARET, CHAR_USCR, CHAR_PCT, CHAR_HASH: begin
				end
				CHAR_LF: begin
					dec.emit = !in_tag;
					dec.data = CHAR_SP;
				end
				default: begin
					dec.emit = !in_tag;
				end
			endcase
		end
	end

endmodule

// File: rtl/htes_emit.sv
// Output register: holds one result byte or steps through a CR LF CR LF run.
module htes_emit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  htes_pkg::dec_t dec,
	output logic           can_load,
	htes_out_if.source     plain
);
	import htes_pkg::*;

	logic       valid_q;
	logic [7:0] data_q;
	logic [1:0] left_q;
	logic       beat;

	assign beat     = valid_q && plain.ready;
	assign can_load = !valid_q || (plain.ready && left_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			left_q  <= 2'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			left_q  <= dec.run ? RUN_LEFT : 2'd0;
		end else if (beat) begin
			if (left_q != 2'd0) begin
				left_q <= left_q - 2'd1;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= dec.data;
		end else if (beat && left_q != 2'd0) begin
			data_q <= (data_q == CHAR_CR) ? CHAR_LF : CHAR_CR;
		end
	end

	assign plain.valid       = valid_q;
	assign plain.out_byte    = data_q;
	assign plain.last_of_run = left_q == 2'd0;

endmodule

// File: rtl/html_tag_entity_stripper_unit.sv
// Top level of the tag and entity stripper: input register, state, decode, output.
//
//  channel  dir  payload                                  handshake
//  text     in   text_byte, ahead_one .. ahead_five       valid / ready
//  plain    out  out_byte, last_of_run                    valid / ready
//
// One byte is taken per cycle unless a byte with a result waits for the output; a CR LF CR
// LF run is sent byte by byte, and a byte with a result after it waits in the input register,
// stalling the input until the run has drained; results pass the input and output registers.
// Reset clears the tag flag, the skip count and both valid flags.
// A stalled output holds its byte; the input keeps flowing while the held
// item causes no result or the output register is free to reload.
module html_tag_entity_stripper_unit (
	input  logic      clk,
	input  logic      arst_n,
	htes_in_if.sink   text,
	htes_out_if.source plain
);
	import htes_pkg::*;

	logic       valid_s1;
	logic [7:0] text_s1;
	logic [7:0] a1_s1, a2_s1, a3_s1, a4_s1, a5_s1;
	logic       in_tag_q;
	logic [2:0] skip_q;
	dec_t       dec;
	logic       can_load;
	logic       adv;
	logic       load;

	assign load       = valid_s1 && dec.emit && can_load;
	assign adv        = valid_s1 && (!dec.emit || can_load);
	assign text.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			in_tag_q <= 1'b0;
			skip_q   <= 3'd0;
		end else begin
			if (text.ready) begin
				valid_s1 <= text.valid;
			end
			if (adv) begin
				in_tag_q <= dec.in_tag;
				skip_q   <= dec.skip;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			text_s1 <= text.text_byte;
			a1_s1   <= text.ahead_one;
			a2_s1   <= text.ahead_two;
			a3_s1   <= text.ahead_three;
			a4_s1   <= text.ahead_four;
			a5_s1   <= text.ahead_five;
		end
	end

	htes_decode u_decode (
		.in_tag      (in_tag_q),
		.skip        (skip_q),
		.text_byte   (text_s1),
		.ahead_one   (a1_s1),
		.ahead_two   (a2_s1),
		.ahead_three (a3_s1),
		.ahead_four  (a4_s1),
		.ahead_five  (a5_s1),
		.dec         (dec)
	);

	htes_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.dec      (dec),
		.can_load (can_load),
		.plain    (plain)
	);

`ifndef SYNTH
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && text_s1 == CHAR_NUL |=> !in_tag_q && skip_q == 3'd0)
		else $error("end of text did not clear state");

	a_skip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		skip_q <= SKIP_LONG)
		else $error("skip count out of range");

	a_run_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		plain.valid && !plain.last_of_run |-> plain.out_byte == CHAR_CR ||
		plain.out_byte == CHAR_LF)
		else $error("multi-byte run carries a byte other than CR or LF");

	a_skip_silent: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && skip_q != 3'd0 |-> !dec.emit)
		else $error("result produced while skipping entity bytes");
`endif

endmodule

// File: tb/sv/html_tag_entity_stripper_unit_tb.sv
// Self-checking testbench for the tag and entity stripper: directed table, random text, checker.
module html_tag_entity_stripper_unit_tb;
	import htes_pkg::*;

	localparam int IDLE_LIMIT = 1000;

	typedef struct packed {
		logic [7:0] c, a1, a2, a3, a4, a5;
		logic       fixed;
		logic [2:0] cnt;
		logic [7:0] val;
	} text_req_t;

	typedef struct packed {
		logic [7:0] byte_val;
		logic       last;
	} plain_byte_t;

	localparam logic [7:0] ENTITIES [4][6] = '{
		'{CHAR_AMP, CHAR_L, CHAR_T, CHAR_SEMI, CHAR_NUL, CHAR_NUL},
		'{CHAR_AMP, CHAR_G, CHAR_T, CHAR_SEMI, CHAR_NUL, CHAR_NUL},
		'{CHAR_AMP, CHAR_N, CHAR_B, CHAR_S, CHAR_P, CHAR_SEMI},
		'{CHAR_AMP, CHAR_B, CHAR_U, CHAR_L, CHAR_L, CHAR_SEMI}
	};
	localparam int ENT_LEN [4] = '{4, 4, 6, 6};

	localparam logic [7:0] TEX_CHARS [10] = '{CHAR_TAB, CHAR_BSL, CHAR_DOLR, CHAR_LBRC,
		CHAR_RBRC, CHAR_TILDE, CHAR_CARET, CHAR_USCR, CHAR_PCT, CHAR_HASH};

	localparam text_req_t OPENING_ROWS [25] = '{
		'{"A", "B", "C", "D", "E", "F", 1'b1, 3'd1, "A"},
		'{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 3'd1, 8'hff},
		'{8'h01, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, 1'b1, 3'd1, 8'h01},
		'{CHAR_TAB, "a", "b", "c", "d", "e", 1'b1, 3'd0, CHAR_NUL},
		'{CHAR_BSL, "a", "b", "c", "d", "e", 1'b1, 3'd0, CHAR_NUL},
		'{CHAR_CARET, "x", "y", "z", "w", "v", 1'b1, 3'd0, CHAR_NUL},
		'{CHAR_LF, "a", "b", "c", "d", "e", 1'b1, 3'd1, CHAR_SP},
		'{CHAR_LT, CHAR_P, CHAR_GT, CHAR_LF, "q", "r", 1'b0, 3'd0, CHAR_NUL},
		'{CHAR_P, CHAR_GT, CHAR_LF, "q", "r", "s", 1'b0, 3'd0, CHAR_NUL},
		'{CHAR_LF, CHAR_GT, "q", "r", "s", "t", 1'b0, 3'd0, CHAR_NUL},
		'{CHAR_GT, "q", "r", "s", "t", "u", 1'b1, 3'd0, CHAR_NUL},
		'{CHAR_AMP, CHAR_L, CHAR_T, CHAR_SEMI, "a", "b", 1'b0, 3'd0, CHAR_NUL},
		'{"Z", "Z", "Z", "Z", "Z", "Z", 1'b0, 3'd0, CHAR_NUL},
		'{CHAR_NUL, "k", "m", CHAR_NUL, CHAR_NUL, CHAR_NUL, 1'b1, 3'd0, CHAR_NUL},
		'{"k", CHAR_AMP, CHAR_G, CHAR_T, CHAR_SEMI, "m", 1'b0, 3'd0, CHAR_NUL},
		'{CHAR_AMP, CHAR_G, CHAR_T, CHAR_SEMI, "m", "n", 1'b0, 3'd0, CHAR_NUL},
		'{CHAR_G, CHAR_T, CHAR_SEMI, "m", "n", "o", 1'b0, 3'd0, CHAR_NUL},
		'{CHAR_T, CHAR_SEMI, "m", "n", "o", "p", 1'b0, 3'd0, CHAR_NUL},
		'{CHAR_SEMI, "m", "n", "o", "p", "q", 1'b0, 3'd0, CHAR_NUL},
		'{CHAR_AMP, CHAR_L, CHAR_T, CHAR_NUL, CHAR_NUL, CHAR_NUL, 1'b1, 3'd0, CHAR_NUL},
		'{CHAR_AMP, CHAR_N, CHAR_B, CHAR_S, CHAR_P, CHAR_SEMI, 1'b0, 3'd0, CHAR_NUL},
		'{CHAR_NUL, CHAR_AMP, CHAR_B, CHAR_U, CHAR_L, CHAR_L, 1'b1, 3'd0, CHAR_NUL},
		'{CHAR_AMP, CHAR_B, CHAR_U, CHAR_L, CHAR_L, CHAR_SEMI, 1'b0, 3'd0, CHAR_NUL},
		'{CHAR_U, CHAR_L, CHAR_L, CHAR_SEMI, "x", "y", 1'b0, 3'd0, CHAR_NUL},
		'{CHAR_NUL, "x", "y", CHAR_NUL, CHAR_NUL, CHAR_NUL, 1'b1, 3'd0, CHAR_NUL}
	};

	logic clk;
	logic arst_n;

	htes_in_if  text_ch ();
	htes_out_if plain_ch ();

	html_tag_entity_stripper_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.plain  (plain_ch)
	);

	logic        tag_open;
	logic [2:0]  skip_cnt;
	text_req_t   pending_text_q [$];
	plain_byte_t plain_due_q [$];
	logic [7:0]  text_buf [$];

	int  mismatches;
	int  text_taken;
	int  plain_checked;
	int  para_runs;
	int  entity_hits;
	int  eot_seen;
	int  sent_cnt;
	int  gap_odds;
	int  ready_odds;
	int  stall_left;
	int  ready_cyc;
	int  idle_cycles;
	bit  calm;

	always #1 clk = ~clk;

	function automatic int strip_byte(input logic [7:0] c, a1, a2, a3, a4, a5,
			output logic [3:0][7:0] res);
		int   n;
		logic is_lt, is_gt, is_nbsp, is_bull;
		n = 0;
		res = '0;
		is_lt = a1 == CHAR_L && a2 == CHAR_T && a3 == CHAR_SEMI;
		is_gt = a1 == CHAR_G && a2 == CHAR_T && a3 == CHAR_SEMI;
		is_nbsp = a1 == CHAR_N && a2 == CHAR_B && a3 == CHAR_S && a4 == CHAR_P
			&& a5 == CHAR_SEMI;
		is_bull = a1 == CHAR_B && a2 == CHAR_U && a3 == CHAR_L && a4 == CHAR_L
			&& a5 == CHAR_SEMI;
		if (c == CHAR_NUL) begin
			tag_open = 1'b0;
			skip_cnt = '0;
			eot_seen++;
		end else if (skip_cnt != 0) begin
			skip_cnt = skip_cnt - 3'd1;
		end else begin
			case (c)
				CHAR_LT: begin
					tag_open = 1'b1;
					if (a1 == CHAR_P) begin
						res = {CHAR_LF, CHAR_CR, CHAR_LF, CHAR_CR};
						n = 4;
						para_runs++;
					end
				end
				CHAR_GT: tag_open = 1'b0;
				CHAR_AMP: begin
					if (is_lt) begin
						tag_open = 1'b1;
						skip_cnt = SKIP_SHORT;
						entity_hits++;
					end else if (is_gt) begin
						tag_open = 1'b0;
						skip_cnt = SKIP_SHORT;
						entity_hits++;
					end else if (is_nbsp) begin
						skip_cnt = SKIP_LONG;
						entity_hits++;
					end else if (is_bull) begin
						skip_cnt = SKIP_LONG;
						res[0] = CHAR_STAR;
						n = 1;
						entity_hits++;
					end
				end
				CHAR_TAB, CHAR_BSL, CHAR_DOLR, CHAR_LBRC, CHAR_RBRC, CHAR_TILDE,
				CHAR_CARET, CHAR_USCR, CHAR_PCT, CHAR_HASH: ;
				CHAR_LF: begin
					if (!tag_open) begin
						res[0] = CHAR_SP;
						n = 1;
					end
				end
				default: begin
					if (!tag_open) begin
						res[0] = c;
						n = 1;
					end
				end
			endcase
		end
		return n;
	endfunction

	function automatic logic [7:0] peek(input int idx);
		return (idx < text_buf.size()) ? text_buf[idx] : CHAR_NUL;
	endfunction

	task automatic add_entity(input int which, input int len);
		for (int k = 0; k < len; k++)
			text_buf.push_back(ENTITIES[which][k]);
	endtask

	task automatic add_chunk();
		int kind;
		int len;
		int which;
		kind = $urandom_range(0, 15);
		case (kind)
			4: text_buf.push_back(8'($urandom_range(1, 255)));
			5: begin
				text_buf.push_back(CHAR_LT);
				text_buf.push_back(CHAR_P);
				repeat ($urandom_range(0, 2)) text_buf.push_back(8'($urandom_range(97, 122)));
				text_buf.push_back(CHAR_GT);
			end
			6: begin
				text_buf.push_back(CHAR_LT);
				repeat ($urandom_range(1, 3)) text_buf.push_back(8'($urandom_range(97, 122)));
				text_buf.push_back(CHAR_GT);
			end
			7: begin
				add_entity(0, ENT_LEN[0]);
				repeat ($urandom_range(0, 3)) text_buf.push_back(8'($urandom_range(97, 122)));
				add_entity(1, ENT_LEN[1]);
			end
			8: add_entity(2, ENT_LEN[2]);
			9: add_entity(3, ENT_LEN[3]);
			10: begin
				which = $urandom_range(0, 3);
				add_entity(which, $urandom_range(1, ENT_LEN[which] - 1));
				text_buf.push_back(8'($urandom_range(97, 122)));
			end
			11: text_buf.push_back(TEX_CHARS[$urandom_range(0, 9)]);
			12: text_buf.push_back($urandom_range(0, 1) ? CHAR_LF : CHAR_TAB);
			13: text_buf.push_back(CHAR_NUL);
			default: begin
				len = $urandom_range(1, 4);
				repeat (len) text_buf.push_back(8'($urandom_range(32, 126)));
			end
		endcase
	endtask

	task automatic send_req(input text_req_t r);
		int gap;
		gap = 0;
		if (sent_cnt % 40 == 0)
			gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
		if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds) == 0)
			gap = $urandom_range(1, 13);
		repeat (gap) begin
			@(negedge clk);
			text_ch.valid <= 1'b0;
		end
		@(negedge clk);
		text_ch.valid       <= 1'b1;
		text_ch.text_byte   <= r.c;
		text_ch.ahead_one   <= r.a1;
		text_ch.ahead_two   <= r.a2;
		text_ch.ahead_three <= r.a3;
		text_ch.ahead_four  <= r.a4;
		text_ch.ahead_five  <= r.a5;
		pending_text_q.push_back(r);
		do @(posedge clk); while (!text_ch.ready);
		sent_cnt++;
	endtask

	// predict on every accepted request
	always @(posedge clk) begin : take_text
		logic [3:0][7:0] res;
		int              n;
		text_req_t       hint;
		if (arst_n && text_ch.valid && text_ch.ready) begin
			n = strip_byte(text_ch.text_byte, text_ch.ahead_one, text_ch.ahead_two,
				text_ch.ahead_three, text_ch.ahead_four, text_ch.ahead_five, res);
			hint = pending_text_q.pop_front();
			if (hint.fixed) begin
				n = int'(hint.cnt);
				res[0] = hint.val;
			end
			for (int k = 0; k < n; k++)
				plain_due_q.push_back('{byte_val: res[k], last: (k == n - 1)});
			text_taken++;
		end
	end

	always @(posedge clk) begin : check_plain
		plain_byte_t due;
		if (arst_n && plain_ch.valid && plain_ch.ready) begin
			plain_checked++;
			if (plain_due_q.size() == 0) begin
				$display("%0t: unexpected plain byte %h, none expected", $time,
					plain_ch.out_byte);
				mismatches++;
			end else begin
				due = plain_due_q.pop_front();
				if (plain_ch.out_byte !== due.byte_val) begin
					$display("%0t: out_byte expected %h, got %h", $time, due.byte_val,
						plain_ch.out_byte);
					mismatches++;
				end
				if (plain_ch.last_of_run !== due.last) begin
					$display("%0t: last_of_run expected %b, got %b", $time, due.last,
						plain_ch.last_of_run);
					mismatches++;
				end
			end
		end
	end

	// hold ready low in bursts
	always @(negedge clk) begin
		ready_cyc++;
		if (ready_cyc % 64 == 0)
			ready_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
		if (stall_left != 0) begin
			stall_left--;
			plain_ch.ready <= 1'b0;
		end else if (!calm && ready_odds != 0 && $urandom_range(0, ready_odds) == 0) begin
			stall_left = $urandom_range(0, 12);
			plain_ch.ready <= 1'b0;
		end else begin
			plain_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((text_ch.valid && text_ch.ready) || (plain_ch.valid && plain_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		text_req_t r;
		clk = 1'b0;
		arst_n = 1'b0;
		tag_open = 1'b0;
		skip_cnt = '0;
		calm = 1'b0;
		gap_odds = 0;
		ready_odds = 4;
		stall_left = 0;
		text_ch.valid = 1'b0;
		text_ch.text_byte = '0;
		text_ch.ahead_one = '0;
		text_ch.ahead_two = '0;
		text_ch.ahead_three = '0;
		text_ch.ahead_four = '0;
		text_ch.ahead_five = '0;
		plain_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (OPENING_ROWS[i])
			send_req(OPENING_ROWS[i]);

		while (text_buf.size() < 280)
			add_chunk();
		for (int i = 0; i < text_buf.size(); i++) begin
			calm = (i >= text_buf.size() - 40);
			// drop in a stray request now and then
			if (!calm && $urandom_range(0, 11) == 0) begin
				r = '0;
				if ($urandom_range(0, 1)) begin
					r.c  = 8'($urandom_range(0, 255));
					r.a1 = 8'($urandom_range(0, 255));
					r.a2 = 8'($urandom_range(0, 255));
					r.a3 = 8'($urandom_range(0, 255));
					r.a4 = 8'($urandom_range(0, 255));
					r.a5 = 8'($urandom_range(0, 255));
				end else begin
					r.c  = CHAR_AMP;
					r.a1 = 8'($urandom_range(0, 3));
					r.a2 = ENTITIES[r.a1][2];
					r.a3 = ENTITIES[r.a1][3];
					r.a4 = (ENT_LEN[r.a1] > 4) ? ENTITIES[r.a1][4] : 8'($urandom_range(0, 255));
					r.a5 = (ENT_LEN[r.a1] > 4) ? ENTITIES[r.a1][5] : 8'($urandom_range(0, 255));
					r.a1 = ENTITIES[r.a1][1];
				end
				send_req(r);
			end
			r = '0;
			r.c  = text_buf[i];
			r.a1 = peek(i + 1);
			r.a2 = peek(i + 2);
			r.a3 = peek(i + 3);
			r.a4 = peek(i + 4);
			r.a5 = peek(i + 5);
			send_req(r);
		end

		@(negedge clk);
		text_ch.valid <= 1'b0;
		while (plain_due_q.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("Sent %0d text requests, checked %0d plain bytes.", text_taken, plain_checked);
		$display("Covered %0d paragraph breaks, %0d entities and %0d end-of-text bytes.",
			para_runs, entity_hits, eot_seen);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: files.f
rtl/htes_pkg.sv
rtl/htes_if.sv
rtl/htes_decode.sv
rtl/htes_emit.sv
rtl/html_tag_entity_stripper_unit.sv
tb/sv/html_tag_entity_stripper_unit_tb.sv
